// ===== rtl/core/cube_map_texel_address_defines.svh =====
// ----------------------------------------------------------------------------
// cube map texel address: assertion macros
// Concurrent check wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_TEXEL_ADDRESS_DEFINES_SVH
`define CUBE_MAP_TEXEL_ADDRESS_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every clock edge
`define CMTX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CMTX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define CMTX_ASSERT(label, prop, msg)
`define CMTX_ASSERT_IMPL(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/cmtx_pkg.sv =====
// ----------------------------------------------------------------------------
// cmtx_pkg
// Shared types, widths and helpers of the cube map texel address block.
// ----------------------------------------------------------------------------
package cmtx_pkg;

    localparam int unsigned DIR_W                  = 16;
    localparam int unsigned MAG_W                  = DIR_W + 1;
    localparam int unsigned RES_W                  = 11;
    localparam int unsigned RESM1_W                = 12;
    localparam int unsigned MAXRES_W               = 13;
    localparam int unsigned TEXEL_W                = 10;
    localparam int unsigned FACE_W                 = 3;
    localparam int unsigned DEFAULT_MAX_RESOLUTION = 1024;

    localparam logic [RES_W-1:0]   RES_RESET = 11'd64;
    localparam logic [TEXEL_W-1:0] TEXEL_MAX = 10'd1023;

    typedef enum logic [FACE_W-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } cmtx_face_t;

    // sideband that travels with each item down the pipeline
    typedef struct packed {
        cmtx_face_t face;
        logic       zero;
    } cmtx_tag_t;

    // effective resolution minus one: zero counts as one, large values saturate
    function automatic logic [RESM1_W-1:0] res_minus_one(
        input logic [RES_W-1:0]    res,
        input logic [MAXRES_W-1:0] max_res
    );
        logic [MAXRES_W-1:0] res_ext;
        logic [MAXRES_W-1:0] eff;
        res_ext = MAXRES_W'(res);
        if (res_ext == '0)
        begin
            eff = MAXRES_W'(1);
        end
        else if (res_ext > max_res)
        begin
            eff = max_res;
        end
        else
        begin
            eff = res_ext;
        end
        return RESM1_W'(eff - MAXRES_W'(1));
    endfunction

endpackage

// ===== rtl/core/cmtx_ifs.sv =====
// ----------------------------------------------------------------------------
// cmtx interfaces
// Valid/ready channels for lookup directions and texel addresses.
// ----------------------------------------------------------------------------
interface cmtx_dir_if;
    logic                               valid;
    logic                               ready;
    logic signed [cmtx_pkg::DIR_W-1:0]  dir_x;
    logic signed [cmtx_pkg::DIR_W-1:0]  dir_y;
    logic signed [cmtx_pkg::DIR_W-1:0]  dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmtx_texel_if;
    logic                               valid;
    logic                               ready;
    logic [cmtx_pkg::FACE_W-1:0]        face_index;
    logic [cmtx_pkg::TEXEL_W-1:0]       texel_x;
    logic [cmtx_pkg::TEXEL_W-1:0]       texel_y;
    logic                               zero_direction;

    modport source (output valid, output face_index, output texel_x, output texel_y,
                    output zero_direction, input ready);
    modport sink   (input valid, input face_index, input texel_x, input texel_y,
                    input zero_direction, output ready);
endinterface

// ===== rtl/core/cmtx_face_sel.sv =====
// ----------------------------------------------------------------------------
// cmtx_face_sel
// Pipeline stage picking the major axis and forming the offset numerators.
// ----------------------------------------------------------------------------
module cmtx_face_sel #(
    parameter int unsigned MAX_RESOLUTION = cmtx_pkg::DEFAULT_MAX_RESOLUTION,
    parameter int unsigned QW             = $clog2(MAX_RESOLUTION)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [cmtx_pkg::RES_W-1:0]        res,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [cmtx_pkg::DIR_W-1:0] dir_x,
    input  logic signed [cmtx_pkg::DIR_W-1:0] dir_y,
    input  logic signed [cmtx_pkg::DIR_W-1:0] dir_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cmtx_pkg::cmtx_tag_t               out_tag,
    output logic [cmtx_pkg::MAG_W-1:0]        out_ma,
    output logic [cmtx_pkg::MAG_W-1:0]        out_cu,
    output logic [cmtx_pkg::MAG_W-1:0]        out_cv,
    output logic [QW-1:0]                     out_resm1
);
    import cmtx_pkg::*;

    logic signed [MAG_W-1:0] x_s, y_s, z_s;
    logic signed [MAG_W-1:0] nx_s, ny_s, nz_s;
    logic [MAG_W-1:0]        ax, ay, az;
    logic                    x_pos, y_pos, z_pos;
    logic signed [MAG_W-1:0] uc, vc;
    logic [MAG_W-1:0]        ma_next;
    cmtx_tag_t               tag_next;
    logic [MAG_W:0]          cu_sum, cv_sum;
    logic [RESM1_W-1:0]      resm1_full;

    logic                    valid_reg;
    cmtx_tag_t               tag_reg;
    logic [MAG_W-1:0]        ma_reg, cu_reg, cv_reg;
    logic [QW-1:0]           resm1_reg;

    // magnitudes and signs
    always_comb
    begin
        x_s   = MAG_W'(dir_x);
        y_s   = MAG_W'(dir_y);
        z_s   = MAG_W'(dir_z);
        nx_s  = -x_s;
        ny_s  = -y_s;
        nz_s  = -z_s;
        ax    = dir_x[DIR_W-1] ? nx_s : x_s;
        ay    = dir_y[DIR_W-1] ? ny_s : y_s;
        az    = dir_z[DIR_W-1] ? nz_s : z_s;
        x_pos = !dir_x[DIR_W-1] && (dir_x != '0);
        y_pos = !dir_y[DIR_W-1] && (dir_y != '0);
        z_pos = !dir_z[DIR_W-1] && (dir_z != '0);
    end

    // major axis with ties to x then y, face numerators
    always_comb
    begin
        if (ax >= ay && ax >= az)
        begin
            ma_next       = ax;
            vc            = ny_s;
            tag_next.face = x_pos ? FACE_POS_X : FACE_NEG_X;
            uc            = x_pos ? nz_s : z_s;
        end
        else if (ay >= az)
        begin
            ma_next       = ay;
            uc            = x_s;
            tag_next.face = y_pos ? FACE_POS_Y : FACE_NEG_Y;
            vc            = y_pos ? z_s : nz_s;
        end
        else
        begin
            ma_next       = az;
            vc            = ny_s;
            tag_next.face = z_pos ? FACE_POS_Z : FACE_NEG_Z;
            uc            = z_pos ? x_s : nx_s;
        end
        tag_next.zero = (ma_next == '0);
        // numerator plus magnitude lies in zero to twice the magnitude
        cu_sum     = (MAG_W+1)'(uc) + (MAG_W+1)'(ma_next);
        cv_sum     = (MAG_W+1)'(vc) + (MAG_W+1)'(ma_next);
        resm1_full = res_minus_one(res, MAXRES_W'(MAX_RESOLUTION));
    end

    assign in_ready = !valid_reg || out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            tag_reg   <= tag_next;
            ma_reg    <= ma_next;
            cu_reg    <= cu_sum[MAG_W-1:0];
            cv_reg    <= cv_sum[MAG_W-1:0];
            resm1_reg <= resm1_full[QW-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_ma    = ma_reg;
    assign out_cu    = cu_reg;
    assign out_cv    = cv_reg;
    assign out_resm1 = resm1_reg;

endmodule

// ===== rtl/core/cmtx_scale.sv =====
// ----------------------------------------------------------------------------
// cmtx_scale
// Pipeline stage scaling both numerators by resolution minus one.
// ----------------------------------------------------------------------------
module cmtx_scale #(
    parameter int unsigned QW = 10,
    parameter int unsigned NW = cmtx_pkg::MAG_W + QW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cmtx_pkg::cmtx_tag_t         in_tag,
    input  logic [cmtx_pkg::MAG_W-1:0]  in_ma,
    input  logic [cmtx_pkg::MAG_W-1:0]  in_cu,
    input  logic [cmtx_pkg::MAG_W-1:0]  in_cv,
    input  logic [QW-1:0]               in_resm1,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cmtx_pkg::cmtx_tag_t         out_tag,
    output logic [cmtx_pkg::MAG_W-1:0]  out_den,
    output logic [NW-1:0]               out_num_u,
    output logic [NW-1:0]               out_num_v
);
    import cmtx_pkg::*;

    logic                 valid_reg;
    cmtx_tag_t            tag_reg;
    logic [MAG_W-1:0]     den_reg;
    logic [NW-1:0]        num_u_reg, num_v_reg;
    logic [NW-1:0]        num_u_next, num_v_next;

    // two small products, magnitude doubled for the denominator
    always_comb
    begin
        num_u_next = NW'(in_cu) * NW'(in_resm1);
        num_v_next = NW'(in_cv) * NW'(in_resm1);
    end

    assign in_ready = !valid_reg || out_ready;

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            tag_reg   <= in_tag;
            den_reg   <= {in_ma[MAG_W-2:0], 1'b0};
            num_u_reg <= num_u_next;
            num_v_reg <= num_v_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_den   = den_reg;
    assign out_num_u = num_u_reg;
    assign out_num_v = num_v_reg;

endmodule

// ===== rtl/core/cmtx_div_cell.sv =====
// ----------------------------------------------------------------------------
// cmtx_div_cell
// One restoring division cell: settles one quotient bit for both coordinates.
// ----------------------------------------------------------------------------
module cmtx_div_cell #(
    parameter int unsigned QW  = 10,
    parameter int unsigned NW  = cmtx_pkg::MAG_W + QW,
    parameter int unsigned BIT = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  cmtx_pkg::cmtx_tag_t         in_tag,
    input  logic [cmtx_pkg::MAG_W-1:0]  in_den,
    input  logic [NW-1:0]               in_rem_u,
    input  logic [NW-1:0]               in_rem_v,
    input  logic [QW-1:0]               in_q_u,
    input  logic [QW-1:0]               in_q_v,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cmtx_pkg::cmtx_tag_t         out_tag,
    output logic [cmtx_pkg::MAG_W-1:0]  out_den,
    output logic [NW-1:0]               out_rem_u,
    output logic [NW-1:0]               out_rem_v,
    output logic [QW-1:0]               out_q_u,
    output logic [QW-1:0]               out_q_v
);
    import cmtx_pkg::*;

    logic [NW-1:0]    den_shift;
    logic             take_u, take_v;
    logic [NW-1:0]    rem_u_next, rem_v_next;
    logic [QW-1:0]    q_u_next, q_v_next;

    logic             valid_reg;
    cmtx_tag_t        tag_reg;
    logic [MAG_W-1:0] den_reg;
    logic [NW-1:0]    rem_u_reg, rem_v_reg;
    logic [QW-1:0]    q_u_reg, q_v_reg;

    // trial subtraction of the shifted denominator
    always_comb
    begin
        den_shift     = NW'(in_den) << BIT;
        take_u        = (in_rem_u >= den_shift);
        take_v        = (in_rem_v >= den_shift);
        rem_u_next    = take_u ? (in_rem_u - den_shift) : in_rem_u;
        rem_v_next    = take_v ? (in_rem_v - den_shift) : in_rem_v;
        q_u_next      = in_q_u;
        q_v_next      = in_q_v;
        q_u_next[BIT] = take_u;
        q_v_next[BIT] = take_v;
    end

    assign in_ready = !valid_reg || out_ready;

    // cell valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            tag_reg   <= in_tag;
            den_reg   <= in_den;
            rem_u_reg <= rem_u_next;
            rem_v_reg <= rem_v_next;
            q_u_reg   <= q_u_next;
            q_v_reg   <= q_v_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_den   = den_reg;
    assign out_rem_u = rem_u_reg;
    assign out_rem_v = rem_v_reg;
    assign out_q_u   = q_u_reg;
    assign out_q_v   = q_v_reg;

endmodule

// ===== rtl/core/cube_map_texel_address.sv =====
// ----------------------------------------------------------------------------
// cube_map_texel_address
// Cube map face selection and texel coordinates for a Q2.14 lookup direction.
// Channel dir carries one direction per item; channel texel returns face
// index, texel column and row, and a flag for the all-zero direction.
// cfg_we with cfg_wdata sets the face resolution; write only while idle.
// Stages in order: face select stage, multiply stage, one division cell per
// quotient bit, then the output register. One item per cycle is taken and
// delivered while the texel receiver does not stall.
// Each stage hands on when the next one is empty or moving, so a stalled
// receiver fills the bubbles first and only then drops dir.ready.
// Reset empties the pipeline and sets the resolution to 64.
// ----------------------------------------------------------------------------
`include "cube_map_texel_address_defines.svh"

module cube_map_texel_address #(
    parameter int unsigned MAX_RESOLUTION = cmtx_pkg::DEFAULT_MAX_RESOLUTION
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [cmtx_pkg::RES_W-1:0]  cfg_wdata,
    cmtx_dir_if.sink                    dir,
    cmtx_texel_if.source                texel
);
    import cmtx_pkg::*;

    localparam int unsigned QW  = $clog2(MAX_RESOLUTION);
    localparam int unsigned NW  = MAG_W + QW;
    localparam int unsigned QXW = (QW > TEXEL_W) ? QW : TEXEL_W;

    logic [RES_W-1:0]   res_reg;

    // front stage outputs
    logic               fs_valid, fs_ready;
    cmtx_tag_t          fs_tag;
    logic [MAG_W-1:0]   fs_ma, fs_cu, fs_cv;
    logic [QW-1:0]      fs_resm1;

    // signals between the cells, index 0 is the multiply stage
    logic               c_valid [0:QW];
    logic               c_ready [0:QW];
    cmtx_tag_t          c_tag   [0:QW];
    logic [MAG_W-1:0]   c_den   [0:QW];
    logic [NW-1:0]      c_rem_u [0:QW];
    logic [NW-1:0]      c_rem_v [0:QW];
    logic [QW-1:0]      c_q_u   [0:QW];
    logic [QW-1:0]      c_q_v   [0:QW];

    logic [QXW-1:0]     qx_u, qx_v;
    logic [TEXEL_W-1:0] tx_next, ty_next;

    logic               out_valid_reg;
    cmtx_face_t         face_reg;
    logic [TEXEL_W-1:0] tx_reg, ty_reg;
    logic               zero_reg;
    logic [RESM1_W-1:0] chk_resm1;

    // face resolution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RES_RESET;
        end
        else if (cfg_we)
        begin
            res_reg <= cfg_wdata;
        end
    end

    cmtx_face_sel #(
        .MAX_RESOLUTION (MAX_RESOLUTION),
        .QW             (QW)
    ) u_face_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res_reg),
        .in_valid  (dir.valid),
        .in_ready  (dir.ready),
        .dir_x     (dir.dir_x),
        .dir_y     (dir.dir_y),
        .dir_z     (dir.dir_z),
        .out_valid (fs_valid),
        .out_ready (fs_ready),
        .out_tag   (fs_tag),
        .out_ma    (fs_ma),
        .out_cu    (fs_cu),
        .out_cv    (fs_cv),
        .out_resm1 (fs_resm1)
    );

    cmtx_scale #(
        .QW (QW),
        .NW (NW)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fs_valid),
        .in_ready  (fs_ready),
        .in_tag    (fs_tag),
        .in_ma     (fs_ma),
        .in_cu     (fs_cu),
        .in_cv     (fs_cv),
        .in_resm1  (fs_resm1),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_tag   (c_tag[0]),
        .out_den   (c_den[0]),
        .out_num_u (c_rem_u[0]),
        .out_num_v (c_rem_v[0])
    );

    assign c_q_u[0] = '0;
    assign c_q_v[0] = '0;

    // row of division cells, most significant quotient bit first
    for (genvar k = 0; k < QW; k++)
    begin : g_cell
        cmtx_div_cell #(
            .QW  (QW),
            .NW  (NW),
            .BIT (QW - 1 - k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[k]),
            .in_ready  (c_ready[k]),
            .in_tag    (c_tag[k]),
            .in_den    (c_den[k]),
            .in_rem_u  (c_rem_u[k]),
            .in_rem_v  (c_rem_v[k]),
            .in_q_u    (c_q_u[k]),
            .in_q_v    (c_q_v[k]),
            .out_valid (c_valid[k+1]),
            .out_ready (c_ready[k+1]),
            .out_tag   (c_tag[k+1]),
            .out_den   (c_den[k+1]),
            .out_rem_u (c_rem_u[k+1]),
            .out_rem_v (c_rem_v[k+1]),
            .out_q_u   (c_q_u[k+1]),
            .out_q_v   (c_q_v[k+1])
        );
    end

    // saturate to the output width, zero direction gives texel 0,0
    always_comb
    begin
        qx_u    = QXW'(c_q_u[QW]);
        qx_v    = QXW'(c_q_v[QW]);
        tx_next = (qx_u > QXW'(TEXEL_MAX)) ? TEXEL_MAX : qx_u[TEXEL_W-1:0];
        ty_next = (qx_v > QXW'(TEXEL_MAX)) ? TEXEL_MAX : qx_v[TEXEL_W-1:0];
        if (c_tag[QW].zero)
        begin
            tx_next = '0;
            ty_next = '0;
        end
    end

    assign c_ready[QW] = !out_valid_reg || texel.ready;

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (c_ready[QW])
        begin
            out_valid_reg <= c_valid[QW];
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (c_ready[QW] && c_valid[QW])
        begin
            face_reg <= c_tag[QW].face;
            zero_reg <= c_tag[QW].zero;
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
        end
    end

    assign texel.valid          = out_valid_reg;
    assign texel.face_index     = face_reg;
    assign texel.texel_x        = tx_reg;
    assign texel.texel_y        = ty_reg;
    assign texel.zero_direction = zero_reg;

    assign chk_resm1 = res_minus_one(res_reg, MAXRES_W'(MAX_RESOLUTION));

    // zero direction reports the negative x face at the face origin
    `CMTX_ASSERT_IMPL(a_zero_dir_result,
        texel.valid && texel.zero_direction,
        texel.face_index == FACE_NEG_X && texel.texel_x == '0 && texel.texel_y == '0,
        "zero direction result malformed")

    // texels stay inside the face
    `CMTX_ASSERT_IMPL(a_texel_in_face,
        texel.valid,
        RESM1_W'(texel.texel_x) <= chk_resm1 && RESM1_W'(texel.texel_y) <= chk_resm1,
        "texel beyond face resolution")

    // zero flag set exactly when the major magnitude is zero
    `CMTX_ASSERT(a_zero_flag_match,
        !fs_valid || (fs_tag.zero == (fs_ma == '0)),
        "zero flag out of step with magnitude")

endmodule

// ===== tb/cube_map_texel_address_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_map_texel_address_test
// Drives lookup directions through the cube map texel address block under
// several face resolutions, with bursty input and a stalling receiver. Each
// returned address is compared with an in-bench computation of face and texel.
// ----------------------------------------------------------------------------
module cube_map_texel_address_test;

    import cmtx_pkg::*;

    typedef logic signed [DIR_W-1:0] dir_comp_t;

    // one expected texel address
    typedef struct {
        cmtx_face_t         face;
        logic [TEXEL_W-1:0] texel_x;
        logic [TEXEL_W-1:0] texel_y;
        logic               zero_direction;
    } texel_addr_t;

    localparam int unsigned PIPE_LATENCY   = $clog2(DEFAULT_MAX_RESOLUTION) + 3;
    localparam int unsigned FACE_RES_LIMIT = DEFAULT_MAX_RESOLUTION;
    localparam int unsigned HOLD_CYCLES    = 120;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [RES_W-1:0] cfg_wdata;

    cmtx_dir_if   dir_ch ();
    cmtx_texel_if texel_ch ();

    cube_map_texel_address dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .dir       (dir_ch),
        .texel     (texel_ch)
    );

    // resolution as the block holds it, and the addresses still to come back
    logic [RES_W-1:0] face_res = RES_RESET;
    texel_addr_t      expected_addrs[$];
    int unsigned      error_count = 0;

    // idling controls shared by the sender, the receiver and the tests
    bit          sender_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int unsigned burst_left     = 0;
    int unsigned hold_requests  = 0;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("[cube_map_texel_address] ERROR");
        $finish;
    end

    // texel coordinate for one numerator, clamped to the face and to the field
    function automatic logic [TEXEL_W-1:0] scale_to_texel(
        input logic signed [DIR_W+1:0] numer,
        input logic [MAG_W-1:0]        major,
        input logic [RESM1_W-1:0]      span
    );
        logic signed [DIR_W+2:0] offset;
        logic [63:0]             prod;
        logic [63:0]             quot;
        offset = numer + $signed({2'b00, major});
        prod   = 64'(offset) * 64'(span);
        quot   = prod / (64'(major) * 64'd2);
        if (quot > 64'(span))
        begin
            quot = 64'(span);
        end
        if (quot > 64'(TEXEL_MAX))
        begin
            quot = 64'(TEXEL_MAX);
        end
        return quot[TEXEL_W-1:0];
    endfunction

    // face and texel that a direction maps to at the given resolution
    function automatic texel_addr_t predict_texel_addr(
        input dir_comp_t        x,
        input dir_comp_t        y,
        input dir_comp_t        z,
        input logic [RES_W-1:0] res_reg
    );
        logic signed [DIR_W+1:0] sx;
        logic signed [DIR_W+1:0] sy;
        logic signed [DIR_W+1:0] sz;
        logic signed [DIR_W+1:0] uc;
        logic signed [DIR_W+1:0] vc;
        logic [MAG_W-1:0]        ax;
        logic [MAG_W-1:0]        ay;
        logic [MAG_W-1:0]        az;
        logic [MAG_W-1:0]        major;
        logic [RESM1_W-1:0]      span;
        texel_addr_t             addr;
        sx = x;
        sy = y;
        sz = z;
        ax = MAG_W'(sx < 0 ? -sx : sx);
        ay = MAG_W'(sy < 0 ? -sy : sy);
        az = MAG_W'(sz < 0 ? -sz : sz);

        // zero resolution acts as one, oversize saturates
        if (res_reg == '0)
        begin
            span = '0;
        end
        else if (res_reg > FACE_RES_LIMIT)
        begin
            span = RESM1_W'(FACE_RES_LIMIT - 1);
        end
        else
        begin
            span = RESM1_W'(res_reg) - 1'b1;
        end

        // major axis, ties resolved x first, then y
        if (ax >= ay && ax >= az)
        begin
            major = ax;
            vc    = -sy;
            if (sx > 0)
            begin
                addr.face = FACE_POS_X;
                uc        = -sz;
            end
            else
            begin
                addr.face = FACE_NEG_X;
                uc        = sz;
            end
        end
        else if (ay >= az)
        begin
            major = ay;
            uc    = sx;
            if (sy > 0)
            begin
                addr.face = FACE_POS_Y;
                vc        = sz;
            end
            else
            begin
                addr.face = FACE_NEG_Y;
                vc        = -sz;
            end
        end
        else
        begin
            major = az;
            vc    = -sy;
            if (sz > 0)
            begin
                addr.face = FACE_POS_Z;
                uc        = sx;
            end
            else
            begin
                addr.face = FACE_NEG_Z;
                uc        = -sx;
            end
        end

        if (major == '0)
        begin
            addr.face           = FACE_NEG_X;
            addr.texel_x        = '0;
            addr.texel_y        = '0;
            addr.zero_direction = 1'b1;
        end
        else
        begin
            addr.texel_x        = scale_to_texel(uc, major, span);
            addr.texel_y        = scale_to_texel(vc, major, span);
            addr.zero_direction = 1'b0;
        end
        return addr;
    endfunction

    // offer one direction, keep valid up across bursts, log it once taken
    task automatic send_dir(input dir_comp_t x, input dir_comp_t y, input dir_comp_t z);
        if (sender_gaps_on && burst_left == 0)
        begin
            dir_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left != 0)
        begin
            burst_left--;
        end
        dir_ch.valid <= 1'b1;
        dir_ch.dir_x <= x;
        dir_ch.dir_y <= y;
        dir_ch.dir_z <= z;
        @(posedge clk);
        while (dir_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        expected_addrs.push_back(predict_texel_addr(x, y, z, face_res));
    endtask

    // stop offering and let every outstanding address come back
    task automatic wait_until_idle();
        dir_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_addrs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic set_face_resolution(input logic [RES_W-1:0] value);
        wait_until_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        face_res = value;
    endtask

    // one component: mostly any value, some small ones and some extremes
    function automatic dir_comp_t pick_component();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
        begin
            return dir_comp_t'($urandom);
        end
        else if (roll < 8)
        begin
            return dir_comp_t'(int'($urandom_range(0, 8)) - 4);
        end
        case ($urandom_range(0, 6))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh8001;
            3:       return 16'sh0001;
            4:       return 16'shFFFF;
            5:       return 16'sh4000;
            default: return 16'sh0000;
        endcase
    endfunction

    // random direction, sometimes with two equal magnitudes
    task automatic send_random_dir();
        dir_comp_t x;
        dir_comp_t y;
        dir_comp_t z;
        x = pick_component();
        y = pick_component();
        z = pick_component();
        if ($urandom_range(0, 4) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       y = $urandom_range(0, 1) ? x : -x;
                1:       z = $urandom_range(0, 1) ? y : -y;
                default: z = $urandom_range(0, 1) ? x : -x;
            endcase
        end
        send_dir(x, y, z);
    endtask

    // mostly ordinary sizes, with zero, one, the limit and oversize now and then
    function automatic logic [RES_W-1:0] pick_resolution();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RES_W'($urandom_range(FACE_RES_LIMIT + 1, 2047));
            2:       return RES_W'(1);
            3:       return RES_W'(FACE_RES_LIMIT);
            default: return RES_W'($urandom_range(2, FACE_RES_LIMIT - 1));
        endcase
    endfunction

    // receiver: its own ready pattern, plus a long hold-off on request
    initial
    begin
        int unsigned period;
        int unsigned low_len;
        int unsigned phase;
        int unsigned hold_left;
        int unsigned hold_served;
        period      = 4;
        low_len     = 1;
        phase       = 0;
        hold_left   = 0;
        hold_served = 0;
        texel_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                texel_ch.ready <= 1'b0;
            end
            else if (!sink_stalls_on)
            begin
                texel_ch.ready <= 1'b1;
            end
            else
            begin
                texel_ch.ready <= (phase >= low_len);
                phase++;
                if (phase >= period)
                begin
                    phase   = 0;
                    period  = $urandom_range(2, 9);
                    low_len = $urandom_range(0, period - 1);
                end
            end
        end
    end

    // compare each returned address with the oldest one expected
    texel_addr_t want;

    always @(posedge clk)
    begin
        if (rst_n && texel_ch.valid === 1'b1 && texel_ch.ready === 1'b1)
        begin
            if (expected_addrs.size() == 0)
            begin
                $error("texel address returned with none outstanding: face %0d x %0d y %0d",
                       texel_ch.face_index, texel_ch.texel_x, texel_ch.texel_y);
                error_count++;
            end
            else
            begin
                want = expected_addrs.pop_front();
                if (texel_ch.face_index !== want.face)
                begin
                    $error("face_index expected %0d actual %0d",
                           want.face, texel_ch.face_index);
                    error_count++;
                end
                if (texel_ch.texel_x !== want.texel_x)
                begin
                    $error("texel_x expected %0d actual %0d", want.texel_x, texel_ch.texel_x);
                    error_count++;
                end
                if (texel_ch.texel_y !== want.texel_y)
                begin
                    $error("texel_y expected %0d actual %0d", want.texel_y, texel_ch.texel_y);
                    error_count++;
                end
                if (texel_ch.zero_direction !== want.zero_direction)
                begin
                    $error("zero_direction expected %0d actual %0d",
                           want.zero_direction, texel_ch.zero_direction);
                    error_count++;
                end
            end
        end
    end

    // every face, axis ties, the zero vector and the edges of the face
    task automatic test_directed_directions();
        send_dir(16'sh0000, 16'sh0000, 16'sh0000);
        send_dir(16'sh4000, 16'sh0000, 16'sh0000);
        send_dir(-16'sh4000, 16'sh0000, 16'sh0000);
        send_dir(16'sh0000, 16'sh4000, 16'sh0000);
        send_dir(16'sh0000, -16'sh4000, 16'sh0000);
        send_dir(16'sh0000, 16'sh0000, 16'sh4000);
        send_dir(16'sh0000, 16'sh0000, -16'sh4000);
        send_dir(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_dir(16'sh8000, 16'sh8000, 16'sh8000);
        send_dir(16'sh8000, 16'sh7FFF, 16'sh0000);
        send_dir(16'sd100, -16'sd100, 16'sh0000);
        send_dir(16'sh0000, -16'sd100, 16'sd100);
        send_dir(16'sh0000, 16'sh0000, -16'sd1);
        send_dir(16'sd1, 16'sh0000, 16'sh0000);
        send_dir(-16'sd1, 16'sd1, 16'sh0000);
        send_dir(16'sh7FFF, 16'sh8000, 16'sh0000);
        send_dir(16'sh0000, 16'sh7FFF, 16'sh8000);
        send_dir(16'sh4000, -16'sh4000, 16'sh4000);
        send_dir(16'sh8000, 16'sh0000, 16'sh7FFF);
        send_dir(16'sd12345, -16'sd6789, 16'sd2222);
        send_dir(16'sh0000, 16'sh0000, 16'sh7FFF);
        send_dir(16'sh0000, 16'sh0000, 16'sh8000);
    endtask

    // smallest, largest, zero and oversize resolutions
    task automatic test_resolution_extremes();
        logic [RES_W-1:0] settings[8];
        settings = '{RES_W'(1), RES_W'(2), RES_W'(FACE_RES_LIMIT), RES_W'(0),
                     RES_W'(2047), RES_W'(FACE_RES_LIMIT + 1), RES_W'(FACE_RES_LIMIT - 1),
                     RES_W'(3)};
        foreach (settings[i])
        begin
            set_face_resolution(settings[i]);
            send_dir(16'sh8000, 16'sh0000, 16'sh8000);
            send_dir(16'sh8000, 16'sh0000, 16'sh7FFF);
            send_dir(16'sh0001, 16'sh0001, 16'shFFFF);
            repeat (42) send_random_dir();
        end
    endtask

    // bulk traffic over random resolutions, idling switched per phase
    task automatic test_random_directions();
        for (int phase = 0; phase < 8; phase++)
        begin
            set_face_resolution(pick_resolution());
            sender_gaps_on = (phase % 4 != 2);
            sink_stalls_on = (phase % 4 != 3);
            repeat (105) send_random_dir();
        end
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, filling the pipeline
    task automatic test_output_backpressure();
        set_face_resolution(RES_W'($urandom_range(2, FACE_RES_LIMIT)));
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        hold_requests++;
        repeat (150) send_random_dir();
        sender_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    // reset, tests in turn, then drain and report
    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        dir_ch.valid <= 1'b0;
        dir_ch.dir_x <= '0;
        dir_ch.dir_y <= '0;
        dir_ch.dir_z <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_directions();
        test_resolution_extremes();
        test_random_directions();
        test_output_backpressure();

        wait_until_idle();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (error_count == 0)
        begin
            $display("[cube_map_texel_address] OK");
        end
        else
        begin
            $display("[cube_map_texel_address] ERROR");
        end
        $finish;
    end

endmodule
